// ----- design/gsdf_pixel_mapper_macros.svh -----
// assertion helpers shared by the gsdf block
`ifndef GSDF_PIXEL_MAPPER_MACROS_SVH
`define GSDF_PIXEL_MAPPER_MACROS_SVH

// same-cycle implication
`define GSDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsdf assertion failed");

// next-cycle implication
`define GSDF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsdf assertion failed");

`endif

// ----- design/gsdf_pkg.sv -----
package gsdf_pkg;

  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMAX65 = {1'b0, Q_MAX};

  // polynomial coefficients, nearest 2^-32
  localparam logic signed [63:0] CA = 64'sd307081863787;
  localparam logic signed [63:0] CB = 64'sd406274069064;
  localparam logic signed [63:0] CC = 64'sd180010896943;
  localparam logic signed [63:0] CD = 64'sd42196766911;
  localparam logic signed [63:0] CE = 64'sd1210124516;
  localparam logic signed [63:0] CF = -64'sd5101757575;
  localparam logic signed [63:0] CG = -64'sd773710398;
  localparam logic signed [63:0] CH = 64'sd631828301;
  localparam logic signed [63:0] CH7 = 64'sd7 * CH;
  localparam logic signed [63:0] LN2_Q = 64'sd2977044472;

  localparam int NEWTON_MAX = 50;
  localparam int LN_SQUARINGS = 32;
  localparam int DIV_STEPS = 96;
  localparam int LUT_ENTRIES_DEF = 256;
  localparam int LUM_FRAC_BITS_DEF = 8;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_LUM_MIN = 2'd1;
  localparam logic [1:0] REG_LUM_MAX = 2'd2;
  localparam logic [1:0] REG_LUM_AMBIENT = 2'd3;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } op_req_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sat_clip(input logic signed [64:0] s);
    if (s > SMAX65) return Q_MAX;
    else if (s < -SMAX65) return -Q_MAX;
    else return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return sat_clip(s);
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return sat_clip(s);
  endfunction

  // horner coefficient after step k, for the value or the derivative
  function automatic logic signed [63:0] poly_coef(input logic dj, input logic [2:0] k);
    case ({dj, k})
      4'b0000: return CG;
      4'b0001: return CF;
      4'b0010: return CE;
      4'b0011: return CD;
      4'b0100: return CC;
      4'b0101: return CB;
      4'b0110: return CA;
      4'b1000: return 64'sd6 * CG;
      4'b1001: return 64'sd5 * CF;
      4'b1010: return 64'sd4 * CE;
      4'b1011: return 64'sd3 * CD;
      4'b1100: return 64'sd2 * CC;
      4'b1101: return CB;
      default: return 64'sd0;
    endcase
  endfunction

endpackage

// ----- design/gsdf_mul.sv -----
module gsdf_mul import gsdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  op_req_t            req,
  output logic               done,
  output logic signed [63:0] y
);

  logic          busy;
  logic [2:0]    phase;
  logic [63:0]   ua;
  logic [63:0]   ub;
  logic          neg;
  logic [63:0]   pp;
  logic [1:0]    pp_kind;
  logic          pp_vld;
  logic [127:0]  acc;
  logic [31:0]   opa;
  logic [31:0]   opb;
  logic [63:0]   prod;
  logic [127:0]  pp_sh;
  logic          ovf;
  logic [63:0]   pmag;
  logic signed [63:0] r;

  // partial products: lo*lo, lo*hi, hi*lo, hi*hi
  assign opa  = phase[1] ? ua[63:32] : ua[31:0];
  assign opb  = phase[0] ? ub[63:32] : ub[31:0];
  assign prod = opa * opb;

  always_comb begin
    case (pp_kind)
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  assign ovf  = |acc[127:96];
  assign pmag = acc[95:32];
  assign r    = (ovf || pmag[63]) ? Q_MAX : pmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      phase  <= 3'd0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ua     <= mag(req.a);
        ub     <= mag(req.b);
        neg    <= req.a[63] ^ req.b[63];
        acc    <= '0;
        phase  <= 3'd0;
        pp_vld <= 1'b0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (phase < 3'd4) begin
          pp      <= prod;
          pp_kind <= phase[1:0];
          pp_vld  <= 1'b1;
        end else begin
          pp_vld <= 1'b0;
        end
        if (pp_vld) acc <= acc + pp_sh;
        if (phase == 3'd5) begin
          y    <= neg ? -r : r;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          phase <= phase + 3'd1;
        end
      end
    end
  end

endmodule

// ----- design/gsdf_div.sv -----
module gsdf_div import gsdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  op_req_t            req,
  output logic               done,
  output logic signed [63:0] y
);

  logic          busy;
  logic [6:0]    cnt;
  logic [63:0]   num;
  logic [63:0]   den;
  logic [63:0]   rem;
  logic [63:0]   q;
  logic          ovf;
  logic          neg;
  logic [64:0]   rem_sh;
  logic          ge;
  logic signed [63:0] r;

  // restoring division of (a << 32) by b, one quotient bit per cycle
  assign rem_sh = {rem, num[63]};
  assign ge     = rem_sh >= {1'b0, den};
  assign r      = (ovf || q[63]) ? Q_MAX : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num  <= mag(req.a);
        den  <= mag(req.b);
        neg  <= req.a[63] ^ req.b[63];
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        cnt  <= 7'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt < 7'(DIV_STEPS)) begin
          num <= {num[62:0], 1'b0};
          rem <= ge ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];
          ovf <= ovf | q[63] | q[62];
          q   <= {q[62:0], ge};
          cnt <= cnt + 7'd1;
        end else begin
          y    <= neg ? -r : r;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/gsdf_pixel_mapper.sv -----
// when disabled or when lum_max <= lum_min, the code goes from S_IDLE by way of S_OUT to the output
// mapped items: each newton step normalizes, then takes 33 log products, 13 horner
// products and two divides; up to 50 steps plus two log/polynomial passes
// the block takes no new code until the last one is in the output register, and one
// multiplier and one divider are shared by all steps
// reset: synchronous active high; state, handshake and config registers are reset, datapath registers are not
`include "gsdf_pixel_mapper_macros.svh"

module gsdf_pixel_mapper import gsdf_pkg::*; #(
  parameter int LUT_ENTRIES   = LUT_ENTRIES_DEF,
  parameter int LUM_FRAC_BITS = LUM_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  code_out
);

  localparam int RANGE = LUT_ENTRIES - 1;
  localparam int LSH = 32 - LUM_FRAC_BITS;
  localparam logic signed [63:0] RANGE_Q = 64'(RANGE) <<< 32;

  typedef enum logic [3:0] {
    S_IDLE, S_OUT, S_LN_NORM, S_WAIT, S_POLY, S_POLY_END, S_NT_TOP, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    C_SQ, C_LNFIN, C_POLY, C_FRAC, C_JT, C_DF, C_STEP, C_NORM, C_SCALE
  } cont_t;

  typedef enum logic [1:0] {RT_JMIN, RT_JMAX, RT_NEWTON} ret_t;

  logic        enabled;
  logic [19:0] lum_min;
  logic [19:0] lum_max;
  logic [19:0] lum_ambient;

  state_t st;
  cont_t  cont;
  ret_t   ret;
  logic        pdj;
  logic [2:0]  pk;
  logic [63:0] v;
  logic [5:0]  shift_cnt;
  logic [31:0] frac;
  logic [4:0]  sq_cnt;
  logic [5:0]  it_cnt;
  logic [7:0]  idx_r;
  logic [7:0]  res;
  logic signed [63:0] acc, x, jmin, jmax, jt, f, lum;

  op_req_t mul_req, div_req;
  logic mul_done, div_done;
  logic signed [63:0] mul_y, div_y, op_y;

  logic [7:0]  idx;
  logic [63:0] amb, lmin, lrange;
  logic [63:0] m_sq;
  logic [31:0] frac_new;
  logic signed [31:0] ip;
  logic signed [63:0] acc_new, nxt, dd, dabs, ddl;

  function automatic logic [63:0] lum_q(input logic [20:0] l);
    return 64'(l) << LSH;
  endfunction

  function automatic logic [63:0] ln_arg(input logic [63:0] a);
    return (a == 64'd0) ? 64'd1 : a;
  endfunction

  gsdf_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .y(mul_y));
  gsdf_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .y(div_y));

  assign in_ready = (st == S_IDLE);
  assign idx = ({1'b0, code_in} < 9'(LUT_ENTRIES)) ? code_in : 8'(RANGE);
  assign amb    = lum_q({1'b0, lum_ambient});
  assign lmin   = lum_q({1'b0, lum_min});
  assign lrange = lum_q({1'b0, 20'(lum_max - lum_min)});
  assign op_y   = mul_done ? mul_y : div_y;

  // one squaring step of the log2 loop, then the horner, newton step and output clamp terms
  assign m_sq     = op_y[33] ? {1'b0, op_y[63:1]} : op_y;
  assign frac_new = {frac[30:0], op_y[33]};
  assign ip       = 32'sd31 - 32'(shift_cnt);
  assign acc_new  = sat_add(op_y, poly_coef(pdj, pk));
  assign nxt      = sat_sub(lum, op_y);
  assign dd       = sat_sub(nxt, lum);
  assign dabs     = dd[63] ? -dd : dd;
  assign ddl      = op_y[63] ? 64'sd0 : ((op_y > RANGE_Q) ? RANGE_Q : op_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      lum_min     <= 20'd128;
      lum_max     <= 20'd64000;
      lum_ambient <= 20'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLED:     enabled     <= cfg_data[0];
        REG_LUM_MIN:     lum_min     <= cfg_data;
        REG_LUM_MAX:     lum_max     <= cfg_data;
        REG_LUM_AMBIENT: lum_ambient <= cfg_data;
        default:         enabled     <= enabled;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      it_cnt        <= 6'd0;
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      if (out_valid && out_ready && st != S_OUT) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            idx_r <= idx;
            if (!enabled) begin
              res <= code_in;
              st  <= S_OUT;
            end else if (lum_max <= lum_min) begin
              res <= idx;
              st  <= S_OUT;
            end else begin
              v         <= ln_arg(lum_q({1'b0, lum_min} + {1'b0, lum_ambient}));
              shift_cnt <= 6'd0;
              ret       <= RT_JMIN;
              st        <= S_LN_NORM;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            code_out  <= res;
            out_valid <= 1'b1;
            st        <= S_IDLE;
          end
        end
        S_LN_NORM: begin
          if (v[63]) begin
            frac          <= 32'd0;
            sq_cnt        <= 5'd0;
            mul_req.start <= 1'b1;
            mul_req.a     <= {31'b0, v[63:31]};
            mul_req.b     <= {31'b0, v[63:31]};
            cont          <= C_SQ;
            st            <= S_WAIT;
          end else begin
            v         <= {v[62:0], 1'b0};
            shift_cnt <= shift_cnt + 6'd1;
          end
        end
        S_POLY: begin
          mul_req.start <= 1'b1;
          mul_req.a     <= acc;
          mul_req.b     <= x;
          cont          <= C_POLY;
          st            <= S_WAIT;
        end
        S_POLY_END: begin
          if (pdj) begin
            div_req.start <= 1'b1;
            div_req.a     <= acc;
            div_req.b     <= lum;
            cont          <= C_DF;
            st            <= S_WAIT;
          end else begin
            case (ret)
              RT_JMIN: begin
                jmin      <= acc;
                v         <= ln_arg(lum_q({1'b0, lum_max} + {1'b0, lum_ambient}));
                shift_cnt <= 6'd0;
                ret       <= RT_JMAX;
                st        <= S_LN_NORM;
              end
              RT_JMAX: begin
                jmax          <= acc;
                div_req.start <= 1'b1;
                div_req.a     <= {56'b0, idx_r};
                div_req.b     <= 64'(RANGE);
                cont          <= C_FRAC;
                st            <= S_WAIT;
              end
              default: begin
                f   <= sat_sub(acc, jt);
                acc <= CH7;
                pdj <= 1'b1;
                pk  <= 3'd0;
                st  <= S_POLY;
              end
            endcase
          end
        end
        S_NT_TOP: begin
          if (it_cnt == 6'(NEWTON_MAX)) begin
            st <= S_FIN;
          end else begin
            if (lum <= 64'sd0) begin
              lum <= 64'sd1;
              v   <= 64'd1;
            end else begin
              v <= lum;
            end
            shift_cnt <= 6'd0;
            ret       <= RT_NEWTON;
            st        <= S_LN_NORM;
          end
        end
        S_FIN: begin
          div_req.start <= 1'b1;
          div_req.a     <= sat_sub(sat_sub(lum, amb), lmin);
          div_req.b     <= lrange;
          cont          <= C_NORM;
          st            <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done || div_done) begin
            case (cont)
              C_SQ: begin
                frac          <= frac_new;
                sq_cnt        <= sq_cnt + 5'd1;
                mul_req.start <= 1'b1;
                if (sq_cnt == 5'(LN_SQUARINGS - 1)) begin
                  mul_req.a <= {ip, frac_new};
                  mul_req.b <= LN2_Q;
                  cont      <= C_LNFIN;
                end else begin
                  mul_req.a <= m_sq;
                  mul_req.b <= m_sq;
                end
              end
              C_LNFIN: begin
                x   <= op_y;
                acc <= CH;
                pdj <= 1'b0;
                pk  <= 3'd0;
                st  <= S_POLY;
              end
              C_POLY: begin
                acc <= acc_new;
                pk  <= pk + 3'd1;
                if ((pdj && pk == 3'd5) || (!pdj && pk == 3'd6)) st <= S_POLY_END;
                else st <= S_POLY;
              end
              C_FRAC: begin
                mul_req.start <= 1'b1;
                mul_req.a     <= sat_sub(jmax, jmin);
                mul_req.b     <= op_y;
                cont          <= C_JT;
              end
              C_JT: begin
                jt     <= sat_add(jmin, op_y);
                lum    <= Q_ONE;
                it_cnt <= 6'd0;
                st     <= S_NT_TOP;
              end
              C_DF: begin
                if (op_y == 64'sd0) begin
                  st <= S_FIN;
                end else begin
                  div_req.start <= 1'b1;
                  div_req.a     <= f;
                  div_req.b     <= op_y;
                  cont          <= C_STEP;
                end
              end
              C_STEP: begin
                it_cnt <= it_cnt + 6'd1;
                if (nxt <= 64'sd0) begin
                  lum <= lum >>> 1;
                  st  <= S_NT_TOP;
                end else begin
                  lum <= nxt;
                  // converged when the step is within 2^-33 of the new value
                  if (dabs <= (nxt >>> 33)) st <= S_FIN;
                  else st <= S_NT_TOP;
                end
              end
              C_NORM: begin
                mul_req.start <= 1'b1;
                mul_req.a     <= op_y;
                mul_req.b     <= RANGE_Q;
                cont          <= C_SCALE;
              end
              default: begin
                res <= 8'((ddl + 64'sh8000_0000) >>> 32);
                st  <= S_OUT;
              end
            endcase
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `GSDF_ASSERT_IMP(a_one_unit, mul_req.start, !div_req.start)
  `GSDF_ASSERT_IMP(a_mul_waited, mul_done, st == S_WAIT)
  `GSDF_ASSERT_IMP(a_div_waited, div_done, st == S_WAIT)
  `GSDF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `GSDF_ASSERT_IMP(a_newton_bound, 1'b1, it_cnt <= 6'(NEWTON_MAX))

endmodule

// ----- tb/gsdf_checker.sv -----
module gsdf_checker import gsdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  code_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  code_out,
  output int          errors,
  output int          pending
);

  typedef logic signed [63:0] qv_t;

  logic        map_on;
  logic [19:0] lmin_reg;
  logic [19:0] lmax_reg;
  logic [19:0] lamb_reg;
  logic [7:0]  code_q[$];

  function automatic logic [63:0] qabs(input qv_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic qv_t qadd(input qv_t a, input qv_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (s < -$signed({1'b0, Q_MAX})) return -Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] umulq(input logic [63:0] a, input logic [63:0] b,
                                        output bit ovf);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    ovf = p[127:96] != 0;
    return p[95:32];
  endfunction

  function automatic qv_t qmul(input qv_t a, input qv_t b);
    bit o;
    logic [63:0] p;
    qv_t r;
    p = umulq(qabs(a), qabs(b), o);
    r = (o || p[63]) ? Q_MAX : qv_t'(p);
    return (a[63] ^ b[63]) ? -r : r;
  endfunction

  // (a << 32) / b, saturating
  function automatic qv_t qdiv(input qv_t a, input qv_t b);
    logic [127:0] num;
    logic [127:0] quo;
    qv_t r;
    num = {32'b0, qabs(a), 32'b0};
    quo = num / {64'b0, qabs(b)};
    r = (quo[127:63] != 0) ? Q_MAX : qv_t'(quo[63:0]);
    return (a[63] ^ b[63]) ? -r : r;
  endfunction

  function automatic qv_t qln(input qv_t x);
    logic [63:0] v;
    logic [63:0] m;
    qv_t fr;
    int p;
    bit o;
    v = (x > 0) ? 64'(x) : 64'd1;
    p = 63;
    while (p > 0 && !v[p]) p--;
    m = (p >= 32) ? (v >> (p - 32)) : (v << (32 - p));
    fr = 0;
    for (int i = 0; i < 32; i++) begin
      m = umulq(m, m, o);
      fr = fr <<< 1;
      if (m >= (64'd2 << 32)) begin
        m = m >> 1;
        fr = fr | 64'sd1;
      end
    end
    return qmul(qv_t'(longint'(p - 32) * 64'sd4294967296) + fr, LN2_Q);
  endfunction

  function automatic qv_t jnd_of(input qv_t x);
    qv_t acc;
    acc = CH;
    acc = qadd(qmul(acc, x), CG);
    acc = qadd(qmul(acc, x), CF);
    acc = qadd(qmul(acc, x), CE);
    acc = qadd(qmul(acc, x), CD);
    acc = qadd(qmul(acc, x), CC);
    acc = qadd(qmul(acc, x), CB);
    return qadd(qmul(acc, x), CA);
  endfunction

  function automatic qv_t jnd_slope_of(input qv_t x);
    qv_t acc;
    acc = 64'sd7 * CH;
    acc = qadd(qmul(acc, x), 64'sd6 * CG);
    acc = qadd(qmul(acc, x), 64'sd5 * CF);
    acc = qadd(qmul(acc, x), 64'sd4 * CE);
    acc = qadd(qmul(acc, x), 64'sd3 * CD);
    acc = qadd(qmul(acc, x), 64'sd2 * CC);
    return qadd(qmul(acc, x), CB);
  endfunction

  // newton inversion of the jnd curve, starting at one cd/m2
  function automatic qv_t lum_of_jnd(input qv_t jt);
    qv_t lum, x, f, df, nxt, d;
    lum = Q_ONE;
    for (int i = 0; i < 50; i++) begin
      if (lum <= 0) lum = 1;
      x = qln(lum);
      f = qadd(jnd_of(x), -jt);
      df = qdiv(jnd_slope_of(x), lum);
      if (df == 0) break;
      nxt = qadd(lum, -qdiv(f, df));
      if (nxt <= 0) begin
        lum = lum >>> 1;
        continue;
      end
      d = qadd(nxt, -lum);
      if (d < 0) d = -d;
      lum = nxt;
      if (d <= (nxt >>> 33)) break;
    end
    return lum;
  endfunction

  function automatic qv_t lum_fix(input logic [20:0] v);
    return qv_t'({19'b0, v, 24'b0});
  endfunction

  function automatic logic [7:0] drive_value(input logic [7:0] code);
    qv_t amb, lo, jmin, jmax, fr, jt, lt, lr, ddl;
    logic [63:0] t;
    if (!map_on) return code;
    if (lmax_reg <= lmin_reg) return code;
    amb = lum_fix(lamb_reg);
    lo = lum_fix(lmin_reg);
    jmin = jnd_of(qln(lum_fix(21'(lmin_reg) + 21'(lamb_reg))));
    jmax = jnd_of(qln(lum_fix(21'(lmax_reg) + 21'(lamb_reg))));
    t = {24'b0, code, 32'b0};
    fr = qv_t'(t / 64'd255);
    jt = qadd(jmin, qmul(qadd(jmax, -jmin), fr));
    lt = qadd(lum_of_jnd(jt), -amb);
    lr = lum_fix(21'(lmax_reg - lmin_reg));
    ddl = qmul(qdiv(qadd(lt, -lo), lr), 64'sd255 * Q_ONE);
    if (ddl < 0) ddl = 0;
    if (ddl > 64'sd255 * Q_ONE) ddl = 64'sd255 * Q_ONE;
    t = 64'(ddl) + 64'h8000_0000;
    return t[39:32];
  endfunction

  assign pending = code_q.size();

  always @(posedge clk) begin
    if (rst) begin
      map_on   <= 1'b0;
      lmin_reg <= 20'd128;
      lmax_reg <= 20'd64000;
      lamb_reg <= 20'd0;
      code_q.delete();
      errors <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENABLED:     map_on   <= cfg_data[0];
          REG_LUM_MIN:     lmin_reg <= cfg_data;
          REG_LUM_MAX:     lmax_reg <= cfg_data;
          REG_LUM_AMBIENT: lamb_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) code_q.push_back(drive_value(code_in));
      if (out_valid && out_ready) begin
        if (code_q.size() == 0) begin
          $error("code_out: no item expected, actual %0d", code_out);
          errors <= errors + 1;
        end else begin
          if (code_out !== code_q[0]) begin
            $error("code_out: expected %0d, actual %0d", code_q[0], code_out);
            errors <= errors + 1;
          end
          void'(code_q.pop_front());
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import gsdf_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_ENABLED;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  code_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  code_out;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;

  always #5 clk = ~clk;

  gsdf_pixel_mapper uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .code_in(code_in), .out_valid(out_valid), .out_ready(out_ready),
    .code_out(code_out)
  );

  gsdf_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .code_in(code_in), .out_valid(out_valid), .out_ready(out_ready),
    .code_out(code_out), .errors(errors), .pending(pending)
  );

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      out_ready <= 1'b0;
    end else begin
      if (hold_go) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      out_ready <= !(hold_go || hold_left > 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic set_regs(input logic en, input logic [19:0] lo, input logic [19:0] hi,
                          input logic [19:0] amb);
    logic [19:0] vals[4];
    vals = '{{19'b0, en}, lo, hi, amb};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_code(input logic [7:0] c);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    code_in <= c;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pick_idling(input int ph);
    case (ph % 5)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 76; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 76; end
      3: begin send_idle = 10; recv_stall = 10; end
      default: begin send_idle = 0; recv_stall = 0; end
    endcase
  endtask

  task automatic run_phase(input int ph, input int n_rand);
    pick_idling(ph);
    for (int i = 0; i < n_rand; i++) put_code(8'($urandom_range(255)));
    drain();
  endtask

  initial begin
    logic [7:0] edge_codes[8];
    edge_codes = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'h55, 8'hAA};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: bypass
    foreach (edge_codes[i]) put_code(edge_codes[i]);
    run_phase(0, 40);

    // long receiver hold-off while bypass items keep coming
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 12; i++) put_code(8'($urandom_range(255)));
    drain();

    // default luminances, mapping on
    set_regs(1'b1, 20'd128, 20'd64000, 20'd0);
    foreach (edge_codes[i]) put_code(edge_codes[i]);
    run_phase(1, 8);

    // identity: equal and reversed luminances
    set_regs(1'b1, 20'd5000, 20'd5000, 20'd300);
    run_phase(2, 40);
    set_regs(1'b1, 20'hFFFFF, 20'd0, 20'hFFFFF);
    run_phase(3, 40);

    // zero minimum luminance with full-scale maximum and ambient, then without ambient, then a maximum of one
    set_regs(1'b1, 20'd0, 20'hFFFFF, 20'hFFFFF);
    put_code(8'd0);
    put_code(8'd255);
    run_phase(0, 6);
    set_regs(1'b1, 20'd0, 20'hFFFFF, 20'd0);
    put_code(8'd0);
    put_code(8'd255);
    run_phase(2, 6);
    set_regs(1'b1, 20'd0, 20'd1, 20'd0);
    put_code(8'd0);
    put_code(8'd255);
    run_phase(1, 6);

    // random luminance settings
    for (int k = 0; k < 4; k++) begin
      set_regs(1'b1, 20'($urandom_range(2000)), 20'($urandom_range(300000, 2001)),
               20'($urandom_range(20000)));
      run_phase(k, 6);
    end

    // bypass again with extreme settings left in place
    set_regs(1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    run_phase(3, 60);
    run_phase(1, 40);

    in_valid <= 1'b0;
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/gsdf_pkg.sv
design/gsdf_mul.sv
design/gsdf_div.sv
design/gsdf_pixel_mapper.sv
tb/gsdf_checker.sv
tb/tb_top.sv
